// File: rtl/rmq_pkg.sv
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int S_W       = IN_W + 3;
    localparam int MAG_W     = S_W - 1;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int NSQ_W     = SQ_W + 2;
    localparam int ROOT_W    = NSQ_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int QW        = FRAC_BITS + 1;
    localparam int D_W       = MAG_W + FRAC_BITS + 1;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int NCOMP     = 4;

    // component slots
    localparam int IDX_X = 0;
    localparam int IDX_Y = 1;
    localparam int IDX_Z = 2;
    localparam int IDX_W = 3;

    // matrix element slots, row-major
    localparam int M00 = 0;
    localparam int M01 = 1;
    localparam int M02 = 2;
    localparam int M10 = 3;
    localparam int M11 = 4;
    localparam int M12 = 5;
    localparam int M20 = 6;
    localparam int M21 = 7;
    localparam int M22 = 8;

    localparam logic [1:0] PC_TRACE = 2'd0;
    localparam logic [1:0] PC_X     = 2'd1;
    localparam logic [1:0] PC_Y     = 2'd2;
    localparam logic [1:0] PC_Z     = 2'd3;

    typedef struct packed {
        logic [NCOMP-1:0][MAG_W-1:0] mag;
        logic [NCOMP-1:0]            neg;
        logic [1:0]                  pcase;
    } comp_t;

endpackage

// File: rtl/rmq_front.sv
module rmq_front
    import rmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [9*IN_W-1:0]    in_mat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output comp_t                out_comp,
    output logic [NSQ_W-1:0]     out_nsq
);

    logic signed [IN_W-1:0]  m_in [9];
    logic signed [S_W-1:0]   tr;
    logic [1:0]              pcase_in;

    logic                    a_vld_reg;
    logic signed [IN_W-1:0]  a_m_reg [9];
    logic [1:0]              a_pcase_reg;

    logic signed [S_W-1:0]   u [NCOMP];
    comp_t                   b_next;
    logic                    b_vld_reg;
    comp_t                   b_comp_reg;

    logic                    c_vld_reg;
    comp_t                   c_comp_reg;
    logic [NCOMP-1:0][SQ_W-1:0] c_sq_reg;

    logic                    d_vld_reg;
    comp_t                   d_comp_reg;
    logic [NSQ_W-1:0]        d_nsq_reg;

    logic rdy_a, rdy_b, rdy_c, rdy_d;

    assign rdy_d    = !d_vld_reg || out_ready;
    assign rdy_c    = !c_vld_reg || rdy_d;
    assign rdy_b    = !b_vld_reg || rdy_c;
    assign rdy_a    = !a_vld_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        for (int e = 0; e < 9; e++)
        begin
            m_in[e] = in_mat[e*IN_W +: IN_W];
        end
        tr = S_W'(m_in[M00]) + S_W'(m_in[M11]) + S_W'(m_in[M22]);
        if (tr > 0)
            pcase_in = PC_TRACE;
        else if (m_in[M00] > m_in[M11])
            pcase_in = (m_in[M00] > m_in[M22]) ? PC_X : PC_Z;
        else
            pcase_in = (m_in[M11] > m_in[M22]) ? PC_Y : PC_Z;
    end

    // pivot entry and the three sums or differences
    always_comb
    begin
        logic signed [S_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, one_s;
        e00 = S_W'(a_m_reg[M00]);
        e01 = S_W'(a_m_reg[M01]);
        e02 = S_W'(a_m_reg[M02]);
        e10 = S_W'(a_m_reg[M10]);
        e11 = S_W'(a_m_reg[M11]);
        e12 = S_W'(a_m_reg[M12]);
        e20 = S_W'(a_m_reg[M20]);
        e21 = S_W'(a_m_reg[M21]);
        e22 = S_W'(a_m_reg[M22]);
        one_s = S_W'(ONE);
        case (a_pcase_reg)
            PC_X:
            begin
                u[IDX_X] = e00 - e11 - e22 + one_s;
                u[IDX_W] = e21 - e12;
                u[IDX_Y] = e10 + e01;
                u[IDX_Z] = e20 + e02;
            end
            PC_Y:
            begin
                u[IDX_Y] = e11 - e22 - e00 + one_s;
                u[IDX_W] = e02 - e20;
                u[IDX_Z] = e21 + e12;
                u[IDX_X] = e01 + e10;
            end
            PC_Z:
            begin
                u[IDX_Z] = e22 - e00 - e11 + one_s;
                u[IDX_W] = e10 - e01;
                u[IDX_X] = e02 + e20;
                u[IDX_Y] = e12 + e21;
            end
            default:
            begin
                u[IDX_W] = e00 + e11 + e22 + one_s;
                u[IDX_X] = e21 - e12;
                u[IDX_Y] = e02 - e20;
                u[IDX_Z] = e10 - e01;
            end
        endcase
        for (int c = 0; c < NCOMP; c++)
        begin
            b_next.neg[c] = u[c][S_W-1];
            b_next.mag[c] = u[c][S_W-1] ? MAG_W'(-u[c]) : MAG_W'(u[c]);
        end
        b_next.pcase = a_pcase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                a_vld_reg <= in_valid;
            if (rdy_b)
                b_vld_reg <= a_vld_reg;
            if (rdy_c)
                c_vld_reg <= b_vld_reg;
            if (rdy_d)
                d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            a_m_reg     <= m_in;
            a_pcase_reg <= pcase_in;
        end
        if (rdy_b)
            b_comp_reg <= b_next;
        if (rdy_c)
        begin
            c_comp_reg <= b_comp_reg;
            for (int c = 0; c < NCOMP; c++)
            begin
                c_sq_reg[c] <= SQ_W'(b_comp_reg.mag[c]) * SQ_W'(b_comp_reg.mag[c]);
            end
        end
        if (rdy_d)
        begin
            d_comp_reg <= c_comp_reg;
            d_nsq_reg  <= NSQ_W'(c_sq_reg[0]) + NSQ_W'(c_sq_reg[1])
                        + NSQ_W'(c_sq_reg[2]) + NSQ_W'(c_sq_reg[3]);
        end
    end

    assign out_valid = d_vld_reg;
    assign out_comp  = d_comp_reg;
    assign out_nsq   = d_nsq_reg;

endmodule

// File: rtl/rmq_sqrt.sv
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  comp_t                in_comp,
    input  logic [NSQ_W-1:0]     in_nsq,
    output logic                 out_valid,
    input  logic                 out_ready,
    output comp_t                out_comp,
    output logic [ROOT_W-1:0]    out_root
);

    logic                 vld_reg  [ROOT_W];
    logic [REM_W-1:0]     rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]    root_reg [ROOT_W];
    logic [NSQ_W-1:0]     nsq_reg  [ROOT_W];
    comp_t                comp_reg [ROOT_W];
    logic                 rdy      [ROOT_W+1];

    assign rdy[ROOT_W] = out_ready;
    assign in_ready    = rdy[0];

    // one root bit per stage, two radicand bits shifted in each time
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic                 src_vld;
        logic [REM_W-1:0]     src_rem;
        logic [ROOT_W-1:0]    src_root;
        logic [NSQ_W-1:0]     src_nsq;
        comp_t                src_comp;
        logic [REM_W-1:0]     rem_sh;
        logic [REM_W-1:0]     trial;
        logic [REM_W-1:0]     rem_next;
        logic [ROOT_W-1:0]    root_next;

        if (k == 0)
        begin : g_first
            assign src_vld  = in_valid;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_nsq  = in_nsq;
            assign src_comp = in_comp;
        end
        else
        begin : g_rest
            assign src_vld  = vld_reg[k-1];
            assign src_rem  = rem_reg[k-1];
            assign src_root = root_reg[k-1];
            assign src_nsq  = nsq_reg[k-1];
            assign src_comp = comp_reg[k-1];
        end

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_comb
        begin
            rem_sh = {src_rem[REM_W-3:0], src_nsq[NSQ_W-1 -: 2]};
            trial  = {{(REM_W-ROOT_W-2){1'b0}}, src_root, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {src_root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {src_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (rdy[k])
                vld_reg[k] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                nsq_reg[k]  <= {src_nsq[NSQ_W-3:0], 2'b00};
                comp_reg[k] <= src_comp;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_comp  = comp_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

// File: rtl/rmq_div.sv
module rmq_div
    import rmq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  comp_t                       in_comp,
    input  logic [ROOT_W-1:0]           in_root,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [NCOMP-1:0][QW-1:0]    out_quo,
    output logic [NCOMP-1:0]            out_neg,
    output logic [1:0]                  out_pcase
);

    localparam int NS = QW + 1;

    logic                            vld_reg   [NS];
    logic [ROOT_W-1:0]               div_reg   [NS];
    logic [NCOMP-1:0][ROOT_W-1:0]    rem_reg   [NS];
    logic [NCOMP-1:0][QW-1:0]        low_reg   [NS];
    logic [NCOMP-1:0]                neg_reg   [NS];
    logic [1:0]                      pcase_reg [NS];
    logic                            rdy       [NS+1];

    assign rdy[NS]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic                            src_vld;
        logic [ROOT_W-1:0]               src_div;
        logic [NCOMP-1:0]                src_neg;
        logic [1:0]                      src_pcase;
        logic [NCOMP-1:0][ROOT_W-1:0]    rem_next;
        logic [NCOMP-1:0][QW-1:0]        low_next;

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        if (k == 0)
        begin : g_prep
            // dividend = mag * 2^frac + n/2, rounds half away from zero
            assign src_vld   = in_valid;
            assign src_div   = in_root;
            assign src_neg   = in_comp.neg;
            assign src_pcase = in_comp.pcase;
            always_comb
            begin
                logic [D_W-1:0] dvd;
                for (int c = 0; c < NCOMP; c++)
                begin
                    dvd = {1'b0, in_comp.mag[c], {FRAC_BITS{1'b0}}}
                        + D_W'(in_root >> 1);
                    rem_next[c] = ROOT_W'(dvd[D_W-1:QW]);
                    low_next[c] = dvd[QW-1:0];
                end
            end
        end
        else
        begin : g_step
            // quotient bits shift into the freed low dividend bits
            assign src_vld   = vld_reg[k-1];
            assign src_div   = div_reg[k-1];
            assign src_neg   = neg_reg[k-1];
            assign src_pcase = pcase_reg[k-1];
            always_comb
            begin
                logic [ROOT_W:0] rem_sh;
                logic            qbit;
                for (int c = 0; c < NCOMP; c++)
                begin
                    rem_sh = {rem_reg[k-1][c], low_reg[k-1][c][QW-1]};
                    qbit   = (rem_sh >= {1'b0, div_reg[k-1]});
                    if (qbit)
                        rem_next[c] = ROOT_W'(rem_sh - {1'b0, div_reg[k-1]});
                    else
                        rem_next[c] = rem_sh[ROOT_W-1:0];
                    low_next[c] = {low_reg[k-1][c][QW-2:0], qbit};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (rdy[k])
                vld_reg[k] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                div_reg[k]   <= src_div;
                rem_reg[k]   <= rem_next;
                low_reg[k]   <= low_next;
                neg_reg[k]   <= src_neg;
                pcase_reg[k] <= src_pcase;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_quo   = low_reg[NS-1];
    assign out_neg   = neg_reg[NS-1];
    assign out_pcase = pcase_reg[NS-1];

endmodule

// File: rtl/rotation_matrix_to_quaternion_core.sv
// channel   dir  beat fields (lowest bit up)
// s_axis    in   tdata: r00 r01 r02 r10 r11 r12 r20 r21 r22, 16 bits each
// m_axis    out  tdata: quat_x quat_y quat_z quat_w, 16 bits each; tuser: pivot_case
// cfg       in   cfg_we / cfg_wdata: force_nonnegative_w
//
// one matrix accepted per cycle while m_tready holds no stall; 4 front stages, one root bit
// per stage over 19 stages, 16 divider stages, one output register
// every stage holds its own valid bit, so a stalled output only blocks stages that
// are full and bubbles close up behind it
// rst_n clears all valid bits and sets force_nonnegative_w to 1
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [9*IN_W-1:0]    s_tdata,   // r00 r01 r02 r10 r11 r12 r20 r21 r22
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [4*IN_W-1:0]    m_tdata,   // quat_x quat_y quat_z quat_w
    output logic [1:0]           m_tuser,   // pivot_case
    input  logic                 cfg_we,
    input  logic                 cfg_wdata
);

    logic                         f_valid, f_ready;
    comp_t                        f_comp;
    logic [NSQ_W-1:0]             f_nsq;
    logic                         r_valid, r_ready;
    comp_t                        r_comp;
    logic [ROOT_W-1:0]            r_root;
    logic                         d_valid, d_ready;
    logic [NCOMP-1:0][QW-1:0]     d_quo;
    logic [NCOMP-1:0]             d_neg;
    logic [1:0]                   d_pcase;

    logic                         force_reg;
    logic                         out_vld_reg;
    logic [4*IN_W-1:0]            out_data_reg;
    logic [1:0]                   out_pcase_reg;
    logic [4*IN_W-1:0]            out_data_next;

    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mat    (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_comp  (f_comp),
        .out_nsq   (f_nsq)
    );

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_comp   (f_comp),
        .in_nsq    (f_nsq),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_comp  (r_comp),
        .out_root  (r_root)
    );

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_comp   (r_comp),
        .in_root   (r_root),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_quo   (d_quo),
        .out_neg   (d_neg),
        .out_pcase (d_pcase)
    );

    assign d_ready = !out_vld_reg || m_tready;

    // clamp, apply sign, optional flip so that w is not negative
    always_comb
    begin
        logic              flip;
        logic              sn;
        logic [QW-1:0]     qc;
        logic [IN_W-1:0]   mag16;
        flip = force_reg && d_neg[IDX_W] && (d_quo[IDX_W] != '0);
        for (int c = 0; c < NCOMP; c++)
        begin
            qc    = (d_quo[c] > QW'(ONE)) ? QW'(ONE) : d_quo[c];
            sn    = d_neg[c] ^ flip;
            mag16 = IN_W'(qc);
            out_data_next[c*IN_W +: IN_W] = sn ? -mag16 : mag16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_reg   <= 1'b1;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                force_reg <= cfg_wdata;
            if (d_ready)
                out_vld_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready)
        begin
            out_data_reg  <= out_data_next;
            out_pcase_reg <= d_pcase;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_pcase_reg;

`ifndef ASSERT_OFF
    a_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && force_reg |-> !m_tdata[4*IN_W-1])
        else $error("negative w with flip enabled");

    a_trace_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == PC_TRACE) |-> ($signed(m_tdata[IDX_W*IN_W +: IN_W]) > 0))
        else $error("trace branch gave non-positive w");

    a_x_unit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[IDX_X*IN_W +: IN_W]) <= ONE)
                  && ($signed(m_tdata[IDX_X*IN_W +: IN_W]) >= -ONE))
        else $error("x component beyond unit range");
`endif

endmodule
